// ----- rtl/ps2mpt_pkg.sv -----
// Shared types, codes and constants for the PS/2 mouse packet tracker.
package ps2mpt_pkg;

  // op field codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_RESYNC = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IDLE   = 1'd1;

  localparam logic [15:0] RESYNC_MS_RST = 16'd50;
  localparam logic [15:0] IDLE_MS_RST   = 16'd1000;

  // protocol bytes and header bits
  localparam logic [7:0] ACK_BYTE   = 8'hFA;
  localparam logic [7:0] ENABLE_CMD = 8'hF4;
  localparam int unsigned HDR_SYNC_BIT  = 3;
  localparam int unsigned HDR_XSIGN_BIT = 4;
  localparam int unsigned HDR_YSIGN_BIT = 5;

  localparam logic signed [7:0] DELTA_LIM = 8'sd127;

  // default depth of the front-to-back queue
  localparam int unsigned Q_DEPTH_DEF = 2;

  // classified word handed from the front to the back
  typedef struct packed {
    logic [1:0]         kind;
    logic               is_ack;
    logic               hdr_sync;
    logic [7:0]         rx_byte;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
  } cmd_t;

endpackage

// ----- rtl/ps2mpt_if.sv -----
// Handshake interfaces for the input, result and configuration channels.
interface ps2mpt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [7:0]         rx_byte;
  logic signed [15:0] base_x;
  logic signed [15:0] base_y;

  modport source (output valid, op, rx_byte, base_x, base_y, input ready);
  modport sink (input valid, op, rx_byte, base_x, base_y, output ready);
endinterface

interface ps2mpt_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [2:0]         buttons;
  logic signed [7:0]  delta_x;
  logic signed [7:0]  delta_y;
  logic               send_enable;
  logic               frame_done;

  modport source (output valid, pos_x, pos_y, buttons, delta_x, delta_y, send_enable,
                  frame_done, input ready);
  modport sink (input valid, pos_x, pos_y, buttons, delta_x, delta_y, send_enable,
                frame_done, output ready);
endinterface

interface ps2mpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  addr;
  logic [15:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

// ----- rtl/ps2mpt_front.sv -----
// Front end: accepts input words, classifies them and queues them for the back end.
module ps2mpt_front
  import ps2mpt_pkg::*;
#(
  parameter int unsigned Q_DEPTH = Q_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ps2mpt_in_if.sink   in_word,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(Q_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

  cmd_t             q_mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  cmd_t             cmd_in;

  always_comb begin
    cmd_in.kind     = in_word.op;
    cmd_in.is_ack   = (in_word.rx_byte == ACK_BYTE);
    cmd_in.hdr_sync = in_word.rx_byte[HDR_SYNC_BIT];
    cmd_in.rx_byte  = in_word.rx_byte;
    cmd_in.base_x   = in_word.base_x;
    cmd_in.base_y   = in_word.base_y;
  end

  assign in_word.ready = (count_r != CNT_FULL);
  assign push          = in_word.valid && in_word.ready;
  assign q_valid       = (count_r != '0);
  assign q_cmd         = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (q_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

`ifndef SYNTHESIS
  // back end only pops a word that is there
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (count_r != '0))
    else $error("queue popped while empty");
`endif

endmodule

// ----- rtl/ps2mpt_back.sv -----
// Back end: frame assembly, position tracking, timeouts, queries and result register.
module ps2mpt_back
  import ps2mpt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  cmd_t         q_cmd,
  output logic         q_pop,
  ps2mpt_cfg_if.sink   cfg_word,
  ps2mpt_out_if.source out_word
);

  // frame position codes
  localparam logic [1:0] FP_HDR = 2'd0;
  localparam logic [1:0] FP_X   = 2'd1;
  localparam logic [1:0] FP_Y   = 2'd2;

  localparam logic [15:0] IDLE_SAT = 16'hFFFF;

  logic [15:0]        resync_ms_r;
  logic [15:0]        idle_ms_cfg_r;

  logic [15:0]        acc_x_r, acc_x_nxt;
  logic [15:0]        acc_y_r, acc_y_nxt;
  logic [2:0]         btn_r, btn_nxt;
  logic [7:0]         hdr_r, hdr_nxt;
  logic [7:0]         xb_r, xb_nxt;
  logic [1:0]         fpos_r, fpos_nxt;
  logic [15:0]        idle_ms_r, idle_ms_nxt;
  logic               await_r, await_nxt;

  logic               out_valid_r;
  logic signed [7:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic               send_r, send_nxt;
  logic               done_r, done_nxt;

  logic [15:0]        idle_inc;
  logic [15:0]        move_x, move_y;
  logic signed [16:0] diff_x, diff_y;

  // configuration registers; writes are always taken
  assign cfg_word.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resync_ms_r   <= RESYNC_MS_RST;
      idle_ms_cfg_r <= IDLE_MS_RST;
    end else if (cfg_word.valid) begin
      case (cfg_word.addr)
        REG_RESYNC: resync_ms_r   <= cfg_word.data;
        REG_IDLE:   idle_ms_cfg_r <= cfg_word.data;
        default: ;
      endcase
    end
  end

  assign q_pop = q_valid && (!out_valid_r || out_word.ready);

  assign idle_inc = (idle_ms_r == IDLE_SAT) ? idle_ms_r : idle_ms_r + 16'd1;
  assign move_x   = {{8{hdr_r[HDR_XSIGN_BIT]}}, xb_r};
  assign move_y   = {{8{hdr_r[HDR_YSIGN_BIT]}}, q_cmd.rx_byte};
  assign diff_x   = $signed({acc_x_r[15], acc_x_r}) - $signed({q_cmd.base_x[15], q_cmd.base_x});
  assign diff_y   = $signed({acc_y_r[15], acc_y_r}) - $signed({q_cmd.base_y[15], q_cmd.base_y});

  function automatic logic signed [7:0] clamp_d(input logic signed [16:0] d);
    if (d > 17'sd127) begin
      clamp_d = DELTA_LIM;
    end else if (d < -17'sd127) begin
      clamp_d = -DELTA_LIM;
    end else begin
      clamp_d = d[7:0];
    end
  endfunction

  always_comb begin
    acc_x_nxt   = acc_x_r;
    acc_y_nxt   = acc_y_r;
    btn_nxt     = btn_r;
    hdr_nxt     = hdr_r;
    xb_nxt      = xb_r;
    fpos_nxt    = fpos_r;
    idle_ms_nxt = idle_ms_r;
    await_nxt   = await_r;
    dx_nxt      = '0;
    dy_nxt      = '0;
    send_nxt    = 1'b0;
    done_nxt    = 1'b0;
    case (q_cmd.kind)
      OP_BYTE: begin
        idle_ms_nxt = '0;
        if (await_r && q_cmd.is_ack) begin
          await_nxt = 1'b0;
        end else begin
          case (fpos_r)
            FP_HDR: begin
              if (q_cmd.hdr_sync) begin
                hdr_nxt  = q_cmd.rx_byte;
                fpos_nxt = FP_X;
              end
            end
            FP_X: begin
              xb_nxt   = q_cmd.rx_byte;
              fpos_nxt = FP_Y;
            end
            default: begin
              btn_nxt   = hdr_r[2:0];
              acc_x_nxt = acc_x_r + move_x;
              acc_y_nxt = acc_y_r + move_y;
              fpos_nxt  = FP_HDR;
              done_nxt  = 1'b1;
            end
          endcase
        end
      end
      OP_TICK: begin
        idle_ms_nxt = idle_inc;
        if (fpos_r != FP_HDR && idle_inc >= resync_ms_r) begin
          fpos_nxt = FP_HDR;
          send_nxt = 1'b1;
        end else if (idle_inc >= idle_ms_cfg_r) begin
          send_nxt = 1'b1;
        end
        if (send_nxt) begin
          await_nxt   = 1'b1;
          idle_ms_nxt = '0;
        end
      end
      OP_QUERY: begin
        dx_nxt = clamp_d(diff_x);
        dy_nxt = clamp_d(diff_y);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_x_r     <= '0;
      acc_y_r     <= '0;
      btn_r       <= '0;
      fpos_r      <= FP_HDR;
      idle_ms_r   <= '0;
      await_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        acc_x_r   <= acc_x_nxt;
        acc_y_r   <= acc_y_nxt;
        btn_r     <= btn_nxt;
        fpos_r    <= fpos_nxt;
        idle_ms_r <= idle_ms_nxt;
        await_r   <= await_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // frame bytes and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      hdr_r  <= hdr_nxt;
      xb_r   <= xb_nxt;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      send_r <= send_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.pos_x       = acc_x_r;
  assign out_word.pos_y       = acc_y_r;
  assign out_word.buttons     = btn_r;
  assign out_word.delta_x     = dx_r;
  assign out_word.delta_y     = dy_r;
  assign out_word.send_enable = send_r;
  assign out_word.frame_done  = done_r;

`ifndef SYNTHESIS
  a_fpos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    fpos_r != 2'd3)
    else $error("frame position out of range");

  a_send_sets_await: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && send_nxt) |=> (await_r && idle_ms_r == '0 && send_r))
    else $error("enable request without awaiting ack");

  a_send_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(send_r && done_r))
    else $error("send_enable and frame_done together");

  a_delta_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (dx_r != 8'h80 && dy_r != 8'h80))
    else $error("delta outside clamp range");
`endif

endmodule

// ----- rtl/ps2mpt_top.sv -----
// Top level of the PS/2 mouse packet tracker.
//
//  channel   dir  handshake          payload
//  in_word   in   valid/ready        op, rx_byte, base_x, base_y
//  out_word  out  valid/ready        pos_x, pos_y, buttons, delta_x, delta_y,
//                                    send_enable, frame_done
//  cfg_word  in   valid/ready (=1)   addr (0 resync ms, 1 idle ms), data
//
// One word per cycle sustained while out_word is ready; a word's result passes through
// a queue slot and then the result register before it goes valid on out_word.
// The back end updates all tracker state in the single cycle it pops a word.
// The Q_DEPTH-entry queue lets in_word keep accepting while out_word stalls;
// in_word.ready drops only when the queue is full.
// rst_n is synchronous: empties the queue, clears position, buttons, frame
// position, idle count and ack flag, and loads the timeout defaults (50/1000).
// No clearing pass; the block takes words as soon as reset is released.
module ps2_mouse_packet_tracker_top
  import ps2mpt_pkg::*;
#(
  parameter int unsigned Q_DEPTH = Q_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ps2mpt_in_if.sink    in_word,
  ps2mpt_out_if.source out_word,
  ps2mpt_cfg_if.sink   cfg_word
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  // classify and buffer incoming words
  ps2mpt_front #(
    .Q_DEPTH (Q_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // tracker state, timeouts, queries and result register
  ps2mpt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .cfg_word (cfg_word),
    .out_word (out_word)
  );

endmodule

// ----- sim/ps2_mouse_packet_tracker_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the PS/2 mouse packet tracker top level.
//
// Stimulus goes in on in_word and results come back on out_word. Every accepted
// input word produces exactly one result word, in the order the words were accepted.
// A behavioral tracker inside the testbench follows each accepted word. It keeps
// its own copy of position, buttons, frame slot, idle count, ack flag and both
// timeouts, and queues the result that the block must return.
//
// Run outline:
//   - reset (sync, active low)
//   - directed rows: query and base extremes, the unused op, a non-sync byte,
//     0xFA taken as a header when no ack is awaited, full-range moves with both
//     signs, resync drop of a partial frame, a non-ack byte while an ack is
//     awaited, ack swallowing, the idle re-enable, zero timeouts (fire on every
//     tick). Rows whose result is obvious carry a typed-in expected word.
//   - three random phases with different timeout settings and pacing:
//     sender 15% / receiver 60% idle, then 60% / 15%, then no idling.
//     Mostly well-formed frames with random content, mixed with tick runs,
//     queries, ack bytes, noise bytes, broken frames and the unused op.
//   - receiver hold-offs while the sender keeps pushing (fills the internal
//     queue), and a sender pause until drained
// Config writes happen only with nothing in flight.
module ps2_mouse_packet_tracker_top_tb;
  import ps2mpt_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 100;      // cap on detailed mismatch lines
  localparam logic [15:0] IDLE_MS_MAX = 16'hFFFF;

  // one result word
  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [2:0]         buttons;
    logic signed [7:0]  delta_x;
    logic signed [7:0]  delta_y;
    logic               send_enable;
    logic               frame_done;
  } report_t;

  // which byte of a frame comes next
  typedef enum logic [1:0] {
    AT_HEADER,
    AT_X,
    AT_Y
  } slot_e;

  typedef enum logic {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  // one directed row: an input word (optionally with a typed-in result) or a reg write
  typedef struct {
    row_kind_e              kind;
    logic [1:0]             op;
    logic [7:0]             rx_byte;
    logic signed [15:0]     base_x;
    logic signed [15:0]     base_y;
    logic [CFG_ADDR_W-1:0]  reg_idx;
    logic [15:0]            reg_val;
    bit                     pinned;
    report_t                want;
  } row_t;

  logic clk;
  logic rst_n;

  ps2mpt_in_if  in_ch ();
  ps2mpt_out_if out_ch ();
  ps2mpt_cfg_if cfg_ch ();

  ps2_mouse_packet_tracker_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_ch),
    .out_word (out_ch),
    .cfg_word (cfg_ch)
  );

  // --- tracker state (testbench's own copy) ---
  logic [15:0] trk_acc_x;
  logic [15:0] trk_acc_y;
  logic [2:0]  trk_buttons;
  logic [7:0]  trk_hdr;
  logic [7:0]  trk_xbyte;
  slot_e       trk_slot;
  logic [15:0] trk_idle_ms;
  logic        trk_await_ack;
  logic [15:0] trk_resync_ms;
  logic [15:0] trk_reenable_ms;

  report_t pending_reports[$];   // results owed by the block, oldest first
  row_t    directed_rows[$];

  // pinned expectation travels with the word, sampled at the accepting edge
  logic    pin_on;
  report_t pin_want;

  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned enables_seen;
  int unsigned queries_seen;

  int unsigned src_gap_pct;
  int unsigned sink_gap_pct;
  int unsigned hold_reqs;

  // --- clock ---
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --- time limit ---
  initial begin
    #4_000_000;
    $display("ps2_mouse_packet_tracker_top_tb NOT OK");
    $finish;
  end

  function automatic void tracker_reset();
    trk_acc_x       = '0;
    trk_acc_y       = '0;
    trk_buttons     = '0;
    trk_hdr         = '0;
    trk_xbyte       = '0;
    trk_slot        = AT_HEADER;
    trk_idle_ms     = '0;
    trk_await_ack   = 1'b0;
    trk_resync_ms   = RESYNC_MS_RST;
    trk_reenable_ms = IDLE_MS_RST;
  endfunction

  // exact difference, then clamp to +/-127
  function automatic logic signed [7:0] clamp_delta(logic signed [15:0] pos,
                                                    logic signed [15:0] base);
    int d;
    int lim;
    lim = DELTA_LIM;
    d = int'(pos) - int'(base);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return 8'(d);
  endfunction

  // advance the tracker by one accepted word and return the result it owes
  function automatic report_t advance_tracker(logic [1:0] op, logic [7:0] b,
                                              logic signed [15:0] bx,
                                              logic signed [15:0] by);
    report_t r;
    logic [15:0] mx;
    logic [15:0] my;
    r = '0;
    case (op)
      OP_BYTE: begin
        trk_idle_ms = '0;
        if (trk_await_ack && b == ACK_BYTE) begin
          trk_await_ack = 1'b0;          // ack swallowed
        end else if (trk_slot == AT_HEADER) begin
          if (b[HDR_SYNC_BIT]) begin
            trk_hdr  = b;
            trk_slot = AT_X;
          end
        end else if (trk_slot == AT_X) begin
          trk_xbyte = b;
          trk_slot  = AT_Y;
        end else begin
          mx = {{8{trk_hdr[HDR_XSIGN_BIT]}}, trk_xbyte};
          my = {{8{trk_hdr[HDR_YSIGN_BIT]}}, b};
          trk_buttons  = trk_hdr[2:0];
          trk_acc_x    = trk_acc_x + mx;
          trk_acc_y    = trk_acc_y + my;
          trk_slot     = AT_HEADER;
          r.frame_done = 1'b1;
        end
      end
      OP_TICK: begin
        if (trk_idle_ms != IDLE_MS_MAX) trk_idle_ms = trk_idle_ms + 16'd1;
        if (trk_slot != AT_HEADER && trk_idle_ms >= trk_resync_ms) begin
          trk_slot      = AT_HEADER;     // partial frame dropped
          r.send_enable = 1'b1;
        end else if (trk_idle_ms >= trk_reenable_ms) begin
          r.send_enable = 1'b1;
        end
        if (r.send_enable) begin
          trk_await_ack = 1'b1;
          trk_idle_ms   = '0;
        end
      end
      OP_QUERY: begin
        r.delta_x = clamp_delta(trk_acc_x, bx);
        r.delta_y = clamp_delta(trk_acc_y, by);
      end
      default: ;
    endcase
    r.pos_x   = trk_acc_x;
    r.pos_y   = trk_acc_y;
    r.buttons = trk_buttons;
    return r;
  endfunction

  function automatic void flag_field(string name, logic signed [31:0] want,
                                     logic signed [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $error("%s: expected %0d, got %0d", name, want, got);
  endfunction

  function automatic void check_report(report_t got, report_t want);
    if (got.pos_x !== want.pos_x) flag_field("pos_x", want.pos_x, got.pos_x);
    if (got.pos_y !== want.pos_y) flag_field("pos_y", want.pos_y, got.pos_y);
    if (got.buttons !== want.buttons) flag_field("buttons", want.buttons, got.buttons);
    if (got.delta_x !== want.delta_x) flag_field("delta_x", want.delta_x, got.delta_x);
    if (got.delta_y !== want.delta_y) flag_field("delta_y", want.delta_y, got.delta_y);
    if (got.send_enable !== want.send_enable)
      flag_field("send_enable", want.send_enable, got.send_enable);
    if (got.frame_done !== want.frame_done)
      flag_field("frame_done", want.frame_done, got.frame_done);
  endfunction

  // --- monitor: config writes, accepted input words, returned results ---
  always @(posedge clk) begin
    report_t got;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          REG_RESYNC: trk_resync_ms = cfg_ch.data;
          REG_IDLE:   trk_reenable_ms = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.op == OP_QUERY) queries_seen++;
        got = advance_tracker(in_ch.op, in_ch.rx_byte, in_ch.base_x, in_ch.base_y);
        pending_reports.push_back(pin_on ? pin_want : got);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.pos_x       = out_ch.pos_x;
        got.pos_y       = out_ch.pos_y;
        got.buttons     = out_ch.buttons;
        got.delta_x     = out_ch.delta_x;
        got.delta_y     = out_ch.delta_y;
        got.send_enable = out_ch.send_enable;
        got.frame_done  = out_ch.frame_done;
        results_seen++;
        if (got.frame_done === 1'b1) frames_seen++;
        if (got.send_enable === 1'b1) enables_seen++;
        if (pending_reports.size() == 0) begin
          mismatches++;
          $error("result word with nothing expected");
        end else begin
          check_report(got, pending_reports.pop_front());
        end
      end
    end
  end

  // --- receiver: random back-pressure plus requested long hold-offs ---
  initial begin
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  function automatic report_t mk_report(logic signed [15:0] px, logic signed [15:0] py,
                                        logic [2:0] btn, logic signed [7:0] dx,
                                        logic signed [7:0] dy, logic se, logic fd);
    report_t r;
    r = '{px, py, btn, dx, dy, se, fd};
    return r;
  endfunction

  function automatic void add_word(logic [1:0] op, logic [7:0] b,
                                   logic signed [15:0] bx, logic signed [15:0] by);
    row_t r;
    r = '{ROW_WORD, op, b, bx, by, '0, '0, 1'b0, '0};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_pinned(logic [1:0] op, logic [7:0] b,
                                     logic signed [15:0] bx, logic signed [15:0] by,
                                     report_t want);
    row_t r;
    r = '{ROW_WORD, op, b, bx, by, '0, '0, 1'b1, want};
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
    row_t r;
    r = '{ROW_CFG, OP_NONE, '0, '0, '0, idx, val, 1'b0, '0};
    directed_rows.push_back(r);
  endfunction

  // offer one word, with random sender gaps, until it is taken
  task automatic send_word(logic [1:0] op, logic [7:0] b, logic signed [15:0] bx,
                           logic signed [15:0] by, logic pin, report_t want);
    while ($urandom_range(99) < src_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.rx_byte <= b;
    in_ch.base_x  <= bx;
    in_ch.base_y  <= by;
    pin_on        <= pin;
    pin_want      <= want;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic put_byte(logic [7:0] b);
    send_word(OP_BYTE, b, 16'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  task automatic put_ticks(int unsigned n);
    repeat (n) send_word(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
  endtask

  // sender stops offering until every owed result has come back; it lets the
  // monitor book the last accepted word before checking what is still owed
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_burst(int unsigned count);
    int unsigned start;
    int unsigned pick;
    logic [7:0]  hdr;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    start = words_sent;
    while (words_sent - start < count) begin
      pick = $urandom_range(99);
      hdr  = 8'($urandom) | (8'h1 << HDR_SYNC_BIT);
      if (pick < 55) begin
        // well-formed frame, sometimes led by an ack, sometimes with ticks inside
        if ($urandom_range(4) == 0) put_byte(ACK_BYTE);
        put_byte(hdr);
        if ($urandom_range(9) == 0) put_ticks($urandom_range(1, 3));
        put_byte(8'($urandom));
        if ($urandom_range(9) == 0) put_ticks($urandom_range(1, 3));
        put_byte(8'($urandom));
      end else if (pick < 70) begin
        put_ticks($urandom_range(1, 12));
      end else if (pick < 80) begin
        // near the current position half the time (offset -150 to 150), so most deltas land unclamped
        if ($urandom_range(1) == 0) begin
          bx = trk_acc_x + 16'($urandom_range(300)) - 16'd150;
          by = trk_acc_y + 16'($urandom_range(300)) - 16'd150;
        end else begin
          bx = 16'($urandom);
          by = 16'($urandom);
        end
        send_word(OP_QUERY, 8'($urandom), bx, by, 1'b0, '0);
      end else if (pick < 86) begin
        put_byte(ACK_BYTE);
      end else if (pick < 92) begin
        put_byte(8'($urandom));
      end else if (pick < 95) begin
        send_word(OP_NONE, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, '0);
      end else begin
        // broken frame: header and sometimes one more byte, then ticks
        put_byte(hdr);
        if ($urandom_range(1) == 0) put_byte(8'($urandom));
        put_ticks($urandom_range(1, 10));
      end
    end
  endtask

  // --- main sequence ---
  initial begin
    int unsigned guard;
    tracker_reset();
    mismatches     = 0;
    words_sent     = 0;
    results_seen   = 0;
    frames_seen    = 0;
    enables_seen   = 0;
    queries_seen   = 0;
    hold_reqs      = 0;
    src_gap_pct    = 15;
    sink_gap_pct   = 60;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_NONE;
    in_ch.rx_byte  = '0;
    in_ch.base_x   = '0;
    in_ch.base_y   = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.addr    = '0;
    cfg_ch.data    = '0;
    pin_on         = 1'b0;
    pin_want       = '0;

    // directed rows, reset timeouts 50 / 1000
    add_pinned(OP_QUERY, 8'h00, 16'sd0, 16'sd0, mk_report(0, 0, 0, 0, 0, 0, 0));
    add_pinned(OP_QUERY, 8'h00, -16'sd32768, 16'sd32767,
               mk_report(0, 0, 0, 8'sd127, -8'sd127, 0, 0));
    add_pinned(OP_NONE, 8'hFF, -16'sd1, -16'sd1, mk_report(0, 0, 0, 0, 0, 0, 0));
    // no sync bit: dropped
    add_pinned(OP_BYTE, 8'h00, 16'sd0, 16'sd0, mk_report(0, 0, 0, 0, 0, 0, 0));
    // 0xFA with no ack awaited is a valid header: both signs, buttons 2
    add_pinned(OP_BYTE, ACK_BYTE, 16'sd0, 16'sd0, mk_report(0, 0, 0, 0, 0, 0, 0));
    add_pinned(OP_BYTE, 8'hFF, 16'sd0, 16'sd0, mk_report(0, 0, 0, 0, 0, 0, 0));
    add_pinned(OP_BYTE, 8'hFF, 16'sd0, 16'sd0, mk_report(-1, -1, 3'd2, 0, 0, 0, 1));
    // largest positive moves, all buttons
    add_pinned(OP_BYTE, 8'h0F, 16'sd0, 16'sd0, mk_report(-1, -1, 3'd2, 0, 0, 0, 0));
    add_pinned(OP_BYTE, 8'hFF, 16'sd0, 16'sd0, mk_report(-1, -1, 3'd2, 0, 0, 0, 0));
    add_pinned(OP_BYTE, 8'hFF, 16'sd0, 16'sd0, mk_report(254, 254, 3'd7, 0, 0, 0, 1));
    // largest negative moves
    add_word(OP_BYTE, 8'h38, 16'sd0, 16'sd0);
    add_word(OP_BYTE, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_BYTE, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_QUERY, 8'h00, -16'sd2, -16'sd2);
    // short timeouts: resync drop, ack handling, idle re-enable
    add_cfg(REG_RESYNC, 16'd2);
    add_cfg(REG_IDLE, 16'd3);
    add_word(OP_BYTE, 8'h08, 16'sd0, 16'sd0);
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_BYTE, 8'h13, 16'sd0, 16'sd0);   // not an ack: flag stays set
    add_word(OP_BYTE, ACK_BYTE, 16'sd0, 16'sd0); // swallowed
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_BYTE, ACK_BYTE, 16'sd0, 16'sd0);
    // zero timeouts fire on every tick
    add_cfg(REG_RESYNC, 16'd0);
    add_cfg(REG_IDLE, 16'd0);
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);
    add_word(OP_BYTE, 8'h08, 16'sd0, 16'sd0);
    add_word(OP_TICK, 8'h00, 16'sd0, 16'sd0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      end else begin
        send_word(directed_rows[i].op, directed_rows[i].rx_byte, directed_rows[i].base_x,
                  directed_rows[i].base_y, directed_rows[i].pinned, directed_rows[i].want);
      end
    end

    // phase 1: sender idles a little, receiver a lot; long receiver hold-off midway
    write_reg(REG_RESYNC, 16'd4);
    write_reg(REG_IDLE, 16'd9);
    random_burst(300);
    hold_reqs <= hold_reqs + 1;
    random_burst(330);

    // phase 2: roles swapped; sender pauses until drained midway
    src_gap_pct  = 60;
    sink_gap_pct <= 15;
    write_reg(REG_RESYNC, 16'd65535);
    write_reg(REG_IDLE, 16'd6);
    random_burst(300);
    drain();
    random_burst(330);

    // phase 3: no idling on either side, plus another hold-off
    src_gap_pct  = 0;
    sink_gap_pct <= 0;
    write_reg(REG_RESYNC, 16'd1);
    write_reg(REG_IDLE, 16'd5);
    random_burst(300);
    hold_reqs <= hold_reqs + 1;
    random_burst(330);
    in_ch.valid <= 1'b0;

    guard = 0;
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_reports.size() != 0) begin
      mismatches += pending_reports.size();
      $error("%0d expected result words never arrived", pending_reports.size());
    end

    $display("Ran %0d words (%0d results): %0d frames, %0d enable requests, %0d queries,",
             words_sent, results_seen, frames_seen, enables_seen, queries_seen);
    $display("under three pacing mixes, long hold-offs and timeout settings 0 to 65535.");
    if (mismatches == 0) begin
      $display("ps2_mouse_packet_tracker_top_tb OK");
    end else begin
      $display("ps2_mouse_packet_tracker_top_tb NOT OK");
    end
    $finish;
  end

endmodule
